@@ hdl/pipt_pkg.sv @@
package pipt_pkg;

  // Default coordinate width: signed fixed point, 4 fraction bits
  localparam int unsigned COORD_WIDTH_DEFAULT = 20;

  // Per-edge status handed from the operand stage to the compare stage
  typedef struct packed {
    logic straddle;  // edge spans the query y (lower end included)
    logic d_neg;     // end y below start y, compare sense flips
  } edge_flag_t;

endpackage

@@ hdl/pipt_edge_prep.sv @@
// Edge operand preparation: straddle test and the four cross-multiply factors.
// The edge counts when a*b > c*e (d_neg clear) or a*b < c*e (d_neg set).
module pipt_edge_prep #(
  parameter int unsigned COORD_WIDTH = pipt_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic signed [COORD_WIDTH-1:0] xi_i,
  input  logic signed [COORD_WIDTH-1:0] yi_i,
  input  logic signed [COORD_WIDTH-1:0] xj_i,
  input  logic signed [COORD_WIDTH-1:0] yj_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output logic signed [COORD_WIDTH:0]   a_o,
  output logic signed [COORD_WIDTH:0]   b_o,
  output logic signed [COORD_WIDTH:0]   c_o,
  output logic signed [COORD_WIDTH:0]   e_o,
  output pipt_pkg::edge_flag_t          flag_o
);
  import pipt_pkg::*;

  logic signed [COORD_WIDTH:0] xi_w, yi_w, xj_w, yj_w, px_w, py_w;

  // Sign-extend by one bit so differences are exact
  assign xi_w = {xi_i[COORD_WIDTH-1], xi_i};
  assign yi_w = {yi_i[COORD_WIDTH-1], yi_i};
  assign xj_w = {xj_i[COORD_WIDTH-1], xj_i};
  assign yj_w = {yj_i[COORD_WIDTH-1], yj_i};
  assign px_w = {px_i[COORD_WIDTH-1], px_i};
  assign py_w = {py_i[COORD_WIDTH-1], py_i};

  // Factors: (qx - xi) * (yj - yi) against (xj - xi) * (qy - yi)
  assign a_o = px_w - xi_w;
  assign b_o = yj_w - yi_w;
  assign c_o = xj_w - xi_w;
  assign e_o = py_w - yi_w;

  // Half-open straddle of the horizontal line through the query point
  assign flag_o.straddle = ((yi_i <= py_i) && (py_i < yj_i)) ||
                           ((yj_i <= py_i) && (py_i < yi_i));
  assign flag_o.d_neg    = (yj_i < yi_i);

endmodule

@@ hdl/point_in_polygon_test_unit.sv @@
// Even-odd ray-crossing point-in-polygon test. Feed polygon vertices one beat
// each, in order; the beat flagged first_vertex also carries the query point
// (query fields on other beats are ignored) and restarts the parity. The beat
// flagged last_vertex closes the polygon and yields one inside_res beat; other
// beats yield nothing. One vertex is accepted per cycle unless in_stall_o is
// high; a result passes through the input, operand, product and result register
// stages after its last vertex is accepted. Edge tests use exact
// cross-multiplication, so results are bit exact for any input.
module point_in_polygon_test_unit #(
  parameter int unsigned COORD_WIDTH = pipt_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic                          first_vertex_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o
);
  import pipt_pkg::*;

  localparam int unsigned OpW   = COORD_WIDTH + 1;
  localparam int unsigned ProdW = 2 * OpW;

  // Stage valids and handshake
  logic v0_q, v1_q, v2_q, out_valid_q, inside_q, parity_q;
  logic retire2, en2, en1, en0, in_acc, ld1, ld2, out_take, load_out;

  // Polygon state
  logic signed [COORD_WIDTH-1:0] start_x_q, start_y_q, prior_x_q, prior_y_q;
  logic signed [COORD_WIDTH-1:0] point_x_q, point_y_q;

  // Stage 0: registered input beat
  logic signed [COORD_WIDTH-1:0] vx0_q, vy0_q, qx0_q, qy0_q;
  logic                          first0_q, last0_q;

  // Stage 1: edge operands
  logic signed [OpW-1:0] a1_q, b1_q, c1_q, e1_q, a2_q, b2_q, c2_q, e2_q;
  edge_flag_t            f1_q, f2_q;
  logic                  first1_q, last1_q;

  // Stage 2: products
  logic signed [ProdW-1:0] pa1_q, pb1_q, pa2_q, pb2_q;
  edge_flag_t              g1_q, g2_q;
  logic                    first2_q, last2_q;

  // Combinational operand stage
  logic signed [COORD_WIDTH-1:0] start_x_n, start_y_n, point_x_n, point_y_n;
  logic signed [OpW-1:0]         a1_w, b1_w, c1_w, e1_w, a2_w, b2_w, c2_w, e2_w;
  edge_flag_t                    f1_w, f2_w;
  logic                          t1, t2, p_mid, p_new;

  // Flow control: a non-last beat retires even while a result is held
  assign retire2  = v2_q && (!last2_q || !out_valid_q || !out_stall_i);
  assign en2      = !v2_q || retire2;
  assign en1      = !v1_q || en2;
  assign en0      = !v0_q || en1;
  assign ld2      = v1_q && en2;
  assign ld1      = v0_q && en1;
  assign in_acc   = in_valid_i && en0;
  assign out_take = out_valid_q && !out_stall_i;
  assign load_out = retire2 && last2_q;

  assign in_stall_o   = !en0;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // Start and query point as seen by this beat's closing edge
  assign start_x_n = first0_q ? vx0_q : start_x_q;
  assign start_y_n = first0_q ? vy0_q : start_y_q;
  assign point_x_n = first0_q ? qx0_q : point_x_q;
  assign point_y_n = first0_q ? qy0_q : point_y_q;

  // Edge from this vertex back to the previous one
  pipt_edge_prep #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prior (
    .xi_i  (vx0_q),
    .yi_i  (vy0_q),
    .xj_i  (prior_x_q),
    .yj_i  (prior_y_q),
    .px_i  (point_x_q),
    .py_i  (point_y_q),
    .a_o   (a1_w),
    .b_o   (b1_w),
    .c_o   (c1_w),
    .e_o   (e1_w),
    .flag_o(f1_w)
  );

  // Closing edge from the start to this vertex
  pipt_edge_prep #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
    .xi_i  (start_x_n),
    .yi_i  (start_y_n),
    .xj_i  (vx0_q),
    .yj_i  (vy0_q),
    .px_i  (point_x_n),
    .py_i  (point_y_n),
    .a_o   (a2_w),
    .b_o   (b2_w),
    .c_o   (c2_w),
    .e_o   (e2_w),
    .flag_o(f2_w)
  );

  // Compare stage and parity update
  assign t1 = g1_q.straddle && (g1_q.d_neg ? (pa1_q < pb1_q) : (pa1_q > pb1_q));
  assign t2 = g2_q.straddle && (g2_q.d_neg ? (pa2_q < pb2_q) : (pa2_q > pb2_q));
  assign p_mid = first2_q ? 1'b0 : (parity_q ^ t1);
  assign p_new = p_mid ^ t2;

  // Control and polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      parity_q    <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      prior_x_q   <= '0;
      prior_y_q   <= '0;
      point_x_q   <= '0;
      point_y_q   <= '0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      out_valid_q <= load_out || (out_valid_q && !out_take);
      if (retire2) parity_q <= p_new;
      if (ld1) begin
        prior_x_q <= vx0_q;
        prior_y_q <= vy0_q;
        start_x_q <= start_x_n;
        start_y_q <= start_y_n;
        point_x_q <= point_x_n;
        point_y_q <= point_y_n;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vx0_q    <= vertex_x_i;
      vy0_q    <= vertex_y_i;
      qx0_q    <= query_x_i;
      qy0_q    <= query_y_i;
      first0_q <= first_vertex_i;
      last0_q  <= last_vertex_i;
    end
    if (ld1) begin
      a1_q          <= a1_w;
      b1_q          <= b1_w;
      c1_q          <= c1_w;
      e1_q          <= e1_w;
      f1_q.straddle <= f1_w.straddle && !first0_q;
      f1_q.d_neg    <= f1_w.d_neg;
      a2_q          <= a2_w;
      b2_q          <= b2_w;
      c2_q          <= c2_w;
      e2_q          <= e2_w;
      f2_q.straddle <= f2_w.straddle && last0_q;
      f2_q.d_neg    <= f2_w.d_neg;
      first1_q      <= first0_q;
      last1_q       <= last0_q;
    end
    if (ld2) begin
      pa1_q    <= ProdW'(a1_q) * ProdW'(b1_q);
      pb1_q    <= ProdW'(c1_q) * ProdW'(e1_q);
      pa2_q    <= ProdW'(a2_q) * ProdW'(b2_q);
      pb2_q    <= ProdW'(c2_q) * ProdW'(e2_q);
      g1_q     <= f1_q;
      g2_q     <= f2_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
    end
    if (load_out) inside_q <= p_new;
  end

endmodule
